/* hdl/ste_pkg.sv */
// Package for the sorted table engine: widths, command and status codes, types.
// No dependencies.
package ste_pkg;
	localparam int Depth = 128;
	localparam int KeyBits = 32;
	localparam int PayBits = 32;
	localparam int IdxBits = $clog2(Depth);
	localparam int CntBits = IdxBits + 1;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t cmd;
		logic [KeyBits-1:0] key;
		logic [KeyBits-1:0] new_key;
		logic [PayBits-1:0] payload;
	} cmd_item_t;

	typedef struct packed {
		status_t status;
		logic [6:0] found_index;
		logic [31:0] found_payload;
		logic [7:0] entry_total;
	} result_t;
endpackage

/* hdl/ste_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ste_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/ste_front.sv */
// Front end: accepts command transactions into a two-entry queue.
// Depends on ste_pkg.
module ste_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ste_pkg::cmd_item_t in_item,
	output logic q_valid,
	input logic q_pop,
	output ste_pkg::cmd_item_t q_item
);
	import ste_pkg::*;

	cmd_item_t slot_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_item;
	end
endmodule

/* hdl/ste_back.sv */
// Back end: binary search and shifting insert/delete over the entry RAMs.
// Depends on ste_pkg and ste_ram.
module ste_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input ste_pkg::cmd_item_t q_item,
	output logic res_valid,
	input logic res_ready,
	output ste_pkg::result_t res
);
	import ste_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SWAIT, S_SCMP, S_DEL, S_DWAIT, S_INS, S_IWAIT, S_IPUT, S_OUT
	} state_t;

	state_t state_q;
	cmd_item_t it_q;
	logic [CntBits-1:0] count_q, lo_q, hi_q, i_q;
	logic [CntBits-1:0] mid;
	status_t res_status_q;
	logic [6:0] res_index_q;
	logic [31:0] res_payload_q;
	logic we;
	logic [IdxBits-1:0] waddr, raddr;
	logic [KeyBits-1:0] wkey, rkey;
	logic [PayBits-1:0] wpay, rpay;

	// hi_q is exclusive; probe lo + (hi_incl - lo) / 2
	assign mid = lo_q + ((hi_q - lo_q - 1'b1) >> 1);

	ste_ram #(.WIDTH(KeyBits), .DEPTH(Depth)) u_keys (
		.clk, .we, .waddr, .wdata(wkey), .raddr, .rdata(rkey)
	);
	ste_ram #(.WIDTH(PayBits), .DEPTH(Depth)) u_pays (
		.clk, .we, .waddr, .wdata(wpay), .raddr, .rdata(rpay)
	);

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign res_valid = (state_q == S_OUT);

	always_comb begin
		we = 1'b0;
		waddr = i_q[IdxBits-1:0];
		wkey = rkey;
		wpay = rpay;
		raddr = i_q[IdxBits-1:0];
		case (state_q)
			S_SRCH, S_SWAIT: raddr = mid[IdxBits-1:0];
			S_DEL: raddr = IdxBits'(i_q + 1'b1);
			S_DWAIT: we = 1'b1;
			S_INS: raddr = IdxBits'(i_q - 1'b1);
			S_IWAIT: we = (rkey > it_q.key);
			S_IPUT: begin
				we = 1'b1;
				wkey = it_q.key;
				wpay = it_q.payload;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			it_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			res_status_q <= ST_DONE;
			res_index_q <= '0;
			res_payload_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) begin
					it_q <= q_item;
					res_index_q <= '0;
					res_payload_q <= '0;
					res_status_q <= ST_DONE;
					lo_q <= '0;
					hi_q <= count_q;
					i_q <= count_q;
					if (q_item.cmd == CMD_INSERT) begin
						if (count_q == CntBits'(Depth)) begin
							res_status_q <= ST_FULL;
							state_q <= S_OUT;
						end else state_q <= S_INS;
					end else state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (lo_q >= hi_q) begin
						res_status_q <= ST_NOT_FOUND;
						state_q <= S_OUT;
					end else state_q <= S_SWAIT;
				end
				S_SWAIT: state_q <= S_SCMP;
				S_SCMP: begin
					if (rkey == it_q.key) begin
						res_index_q <= 7'(mid);
						if (it_q.cmd == CMD_SEARCH) begin
							res_payload_q <= 32'(rpay);
							state_q <= S_OUT;
						end else begin
							i_q <= mid;
							state_q <= S_DEL;
						end
					end else begin
						if (rkey < it_q.key) lo_q <= mid + 1'b1;
						else hi_q <= mid;
						state_q <= S_SRCH;
					end
				end
				S_DEL: begin
					if (i_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						if (it_q.cmd == CMD_MODIFY) begin
							it_q.key <= it_q.new_key;
							i_q <= count_q - 1'b1;
							state_q <= S_INS;
						end else state_q <= S_OUT;
					end else state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					i_q <= i_q + 1'b1;
					state_q <= S_DEL;
				end
				S_INS: begin
					if (i_q == '0) state_q <= S_IPUT;
					else state_q <= S_IWAIT;
				end
				S_IWAIT: begin
					if (rkey > it_q.key) begin
						i_q <= i_q - 1'b1;
						state_q <= S_INS;
					end else state_q <= S_IPUT;
				end
				S_IPUT: begin
					count_q <= count_q + 1'b1;
					if (it_q.cmd == CMD_INSERT) res_index_q <= 7'(i_q);
					state_q <= S_OUT;
				end
				S_OUT: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res = '{status: res_status_q, found_index: res_index_q,
		found_payload: res_payload_q, entry_total: 8'(count_q)};
endmodule

/* hdl/sorted_table_engine.sv */
// Top level of the sorted table engine: command queue plus table back end.
// Depends on ste_pkg, ste_front, ste_back.
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | cmd[1:0], key[33:2], new_key[65:34], payload[97:66], pad to 104
//  m_axis  | out | status[1:0], found_index[8:2], found_payload[40:9], entry_total[48:41]
// Search makes up to 8 probes, each through S_SRCH, S_SWAIT and S_SCMP;
// insert and delete shift one entry at a time through the entry RAMs;
// a modify of a found key does both, a delete and then an insert.
// Reset clears the entry count and queue; RAM contents are not cleared.
// A two-entry queue lets commands be taken while the back end works or stalls.
module sorted_table_engine (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [103:0] s_axis_tdata, // cmd, key, new_key, payload
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata // status, found_index, found_payload, entry_total
);
	import ste_pkg::*;

	cmd_item_t in_item, q_item;
	result_t res;
	logic q_valid, q_pop;

	assign in_item.cmd = cmd_t'(s_axis_tdata[1:0]);
	assign in_item.key = s_axis_tdata[33:2];
	assign in_item.new_key = s_axis_tdata[65:34];
	assign in_item.payload = s_axis_tdata[97:66];

	ste_front u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item, .q_valid, .q_pop, .q_item
	);
	ste_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {7'd0, res.entry_total, res.found_payload,
		res.found_index, res.status};

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[48:41] <= 8'(Depth)))
		else $error("entry total above depth");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL) |-> m_axis_tdata[48:41] == 8'(Depth))
		else $error("full status with free room");
	a_nf: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] == ST_NOT_FOUND) |-> m_axis_tdata[40:2] == '0)
		else $error("not found result carries data");
endmodule
